// File: hw/rtl/vkvm_pkg.sv
// Shared types, codes and constants for the versioned key/value merge table.
package vkvm_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int DUMP_LIMIT   = 16;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_MERGE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_INSERTED  = 3'd1,
        STS_IGNORED   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic        [31:0] in_version;
        logic               end_of_batch;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
        logic        [31:0] out_version;
        logic               last;
    } out_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic        [31:0] version;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic dump_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_dump;
        logic count_zero;
        logic dump_last;
    } ctrl_sts_t;

endpackage

// File: hw/rtl/vkvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vkvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/vkvm_ctrl.sv
// Controller state machine: sequences accept, execute and dump steps.
module vkvm_ctrl
    import vkvm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        cmd.load_in   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.dump_emit = 1'b0;
        s_ready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (sts.in_dump && !sts.count_zero) ? S_DUMP : S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (sts.out_free) begin
                    cmd.dump_emit = 1'b1;
                    if (sts.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/vkvm_dp.sv
// Datapath: key compare, entry RAM, counters, version clock and output register.
module vkvm_dp
    import vkvm_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_t       s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts
);

    localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int DUMP_N = (DUMP_LIMIT < MAX_KEYS) ? DUMP_LIMIT : MAX_KEYS;

    in_t                in_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] key_reg [MAX_KEYS];
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        clock_reg;
    logic [IDX_W-1:0]   ptr_reg;
    out_t               out_reg;
    logic               m_valid_reg;

    logic [MAX_KEYS-1:0] match;
    logic                hit_c;
    logic [IDX_W-1:0]    idx_c;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;

    logic               full;
    logic [31:0]        clk_inc;
    logic [CNT_W-1:0]   dump_n;
    logic               dump_last;
    out_t               ex_out;
    out_t               dump_out;
    logic               ex_wr;
    logic               ex_ins;
    logic [31:0]        ex_ver;
    logic [31:0]        ex_clk;

    // Parallel key compare over the valid part of the table; keys are unique,
    // so at most one bit of match is set and an OR of indexes encodes it.
    always_comb begin
        idx_c = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            match[i] = (key_reg[i] == s_data.key) && (count_reg > CNT_W'(i));
            if (match[i]) begin
                idx_c = idx_c | IDX_W'(i);
            end
        end
        hit_c = |match;
    end

    assign full      = (count_reg == CNT_W'(MAX_KEYS));
    assign clk_inc   = (clock_reg == '1) ? clock_reg : clock_reg + 32'd1;
    assign dump_n    = (count_reg > CNT_W'(DUMP_N)) ? CNT_W'(DUMP_N) : count_reg;
    assign dump_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == dump_n);

    always_comb begin
        ex_out.status      = STS_NOT_FOUND;
        ex_out.out_key     = in_reg.key;
        ex_out.out_value   = '0;
        ex_out.out_version = '0;
        ex_out.last        = in_reg.end_of_batch;
        ex_wr              = 1'b0;
        ex_ins             = 1'b0;
        ex_ver             = in_reg.in_version;
        ex_clk             = clock_reg;
        case (in_reg.cmd)
            CMD_SET: begin
                ex_out.out_value = in_reg.value;
                if (!hit_reg && full) begin
                    ex_out.status = STS_FULL;
                end else begin
                    ex_wr              = 1'b1;
                    ex_ins             = !hit_reg;
                    ex_ver             = clk_inc;
                    ex_clk             = clk_inc;
                    ex_out.status      = hit_reg ? STS_UPDATED : STS_INSERTED;
                    ex_out.out_version = clk_inc;
                end
            end
            CMD_MERGE: begin
                if (hit_reg && (in_reg.in_version <= rd_entry.version)) begin
                    // equal or older version: report the stored entry
                    ex_out.status      = STS_IGNORED;
                    ex_out.out_value   = rd_entry.value;
                    ex_out.out_version = rd_entry.version;
                end else if (!hit_reg && full) begin
                    ex_out.status    = STS_FULL;
                    ex_out.out_value = in_reg.value;
                end else begin
                    ex_wr              = 1'b1;
                    ex_ins             = !hit_reg;
                    ex_out.status      = hit_reg ? STS_UPDATED : STS_INSERTED;
                    ex_out.out_value   = in_reg.value;
                    ex_out.out_version = in_reg.in_version;
                    if (in_reg.in_version > clock_reg) begin
                        ex_clk = in_reg.in_version;
                    end
                end
            end
            CMD_LOOKUP: begin
                if (hit_reg) begin
                    ex_out.status      = STS_UPDATED;
                    ex_out.out_value   = rd_entry.value;
                    ex_out.out_version = rd_entry.version;
                end
            end
            CMD_DUMP: begin
                // empty table
                ex_out.out_key = '0;
                ex_out.last    = 1'b1;
            end
            default: begin
                ex_wr = 1'b0;
            end
        endcase
    end

    always_comb begin
        dump_out.status      = STS_UPDATED;
        dump_out.out_key     = rd_entry.key;
        dump_out.out_value   = rd_entry.value;
        dump_out.out_version = rd_entry.version;
        dump_out.last        = dump_last;
    end

    assign rd_en   = cmd.load_in | (cmd.dump_emit & !dump_last);
    assign rd_addr = cmd.load_in ? ((s_data.cmd == CMD_DUMP) ? '0 : idx_c)
                                 : ptr_reg + IDX_W'(1);

    assign wr_en            = cmd.exec & ex_wr;
    assign wr_addr          = hit_reg ? idx_reg : count_reg[IDX_W-1:0];
    assign wr_entry.key     = in_reg.key;
    assign wr_entry.value   = in_reg.value;
    assign wr_entry.version = ex_ver;

    vkvm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_KEYS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg  <= s_data;
            hit_reg <= hit_c;
            idx_reg <= idx_c;
        end
        if (wr_en && ex_ins) begin
            key_reg[count_reg[IDX_W-1:0]] <= in_reg.key;
        end
        if (cmd.exec) begin
            out_reg <= ex_out;
        end else if (cmd.dump_emit) begin
            out_reg <= dump_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clock_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                clock_reg <= ex_clk;
                if (ex_wr && ex_ins) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.load_in) begin
                ptr_reg <= '0;
            end else if (cmd.dump_emit) begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
            if (cmd.exec || cmd.dump_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.in_dump    = (s_data.cmd == CMD_DUMP);
    assign sts.count_zero = (count_reg == '0);
    assign sts.dump_last  = dump_last;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: hw/rtl/versioned_key_value_merge_table_unit.sv
// Versioned key/value merge table: top level joining controller and datapath.
//
// Usage: commands arrive on the s_ channel (s_valid/s_ready/s_data) as one
// transaction each: local set, merge of a remote entry, lookup, or dump.
// Results leave on the m_ channel (m_valid/m_ready/m_data). Set, merge and
// lookup give one result each; a dump gives one result per stored entry, up
// to DUMP_LIMIT, with last set on the final one (one not-found result when
// the table is empty).
// Sequence: a command is taken in the idle cycle, its key compared against
// all stored keys in parallel and the matching entry read from the entry
// RAM; the result is then formed and registered in the execute step once the
// output register is free. Set, merge and lookup thus make one RAM read
// followed by the read-modify-write. A dump makes one RAM read per entry.
// Reset (aresetn low, synchronous) empties the table and clears the version
// clock; no clearing pass is needed. When the receiver stalls, the result
// holds in the output register; the block still takes one more command, then
// holds it in the execute step, and does not advance a dump, until that
// transaction completes.
module versioned_key_value_merge_table_unit
    import vkvm_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    vkvm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vkvm_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// File: verif/tb_versioned_key_value_merge_table_unit.sv
// Self-checking testbench for the versioned key/value merge table unit.
module tb_versioned_key_value_merge_table_unit
    import vkvm_pkg::*;
();

    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;
    localparam int POOL_SIZE = 12;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Mirror of the table contents and version clock
    logic [31:0] shadow_key[MAX_KEYS_DEF];
    logic [31:0] shadow_value[MAX_KEYS_DEF];
    logic [31:0] shadow_version[MAX_KEYS_DEF];
    int          shadow_count = 0;
    logic [31:0] shadow_clock = '0;

    out_t        pending_results[$];
    logic [31:0] key_pool[POOL_SIZE];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          sender_gaps = 1'b0;
    int          stall_mode = 0;
    logic [7:0]  stall_phase = '0;

    versioned_key_value_merge_table_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver ready pattern
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_ready <= (stall_phase[3:0] >= 4'd6);
            end
        endcase
    end

    function automatic int find_entry(input logic [31:0] k);
        int slot;
        slot = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (slot < 0 && shadow_key[i] == k) slot = i;
        end
        return slot;
    endfunction

    function automatic void predict_table_results(input in_t item);
        int   slot;
        int   n;
        out_t r;
        slot = find_entry(item.key);
        r.status      = STS_UPDATED;
        r.out_key     = item.key;
        r.out_value   = item.value;
        r.out_version = '0;
        r.last        = item.end_of_batch;
        case (item.cmd)
            CMD_SET: begin
                if (slot < 0 && shadow_count >= MAX_KEYS_DEF) begin
                    r.status = STS_FULL;
                end else begin
                    if (shadow_clock != CLOCK_MAX) shadow_clock = shadow_clock + 1;
                    if (slot < 0) begin
                        slot = shadow_count;
                        shadow_key[slot] = item.key;
                        shadow_count++;
                        r.status = STS_INSERTED;
                    end
                    shadow_value[slot]   = item.value;
                    shadow_version[slot] = shadow_clock;
                    r.out_version = shadow_clock;
                end
                pending_results.push_back(r);
            end
            CMD_MERGE: begin
                if (slot >= 0 && item.in_version <= shadow_version[slot]) begin
                    r.status      = STS_IGNORED;
                    r.out_value   = shadow_value[slot];
                    r.out_version = shadow_version[slot];
                end else if (slot < 0 && shadow_count >= MAX_KEYS_DEF) begin
                    r.status = STS_FULL;
                end else begin
                    if (slot < 0) begin
                        slot = shadow_count;
                        shadow_key[slot] = item.key;
                        shadow_count++;
                        r.status = STS_INSERTED;
                    end
                    shadow_value[slot]   = item.value;
                    shadow_version[slot] = item.in_version;
                    if (item.in_version > shadow_clock) shadow_clock = item.in_version;
                    r.out_version = item.in_version;
                end
                pending_results.push_back(r);
            end
            CMD_LOOKUP: begin
                if (slot >= 0) begin
                    r.out_value   = shadow_value[slot];
                    r.out_version = shadow_version[slot];
                end else begin
                    r.status    = STS_NOT_FOUND;
                    r.out_value = '0;
                end
                pending_results.push_back(r);
            end
            default: begin
                n = (shadow_count > DUMP_LIMIT) ? DUMP_LIMIT : shadow_count;
                if (n == 0) begin
                    r.status  = STS_NOT_FOUND;
                    r.out_key = '0;
                    r.out_value = '0;
                    r.last    = 1'b1;
                    pending_results.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    r.status      = STS_UPDATED;
                    r.out_key     = shadow_key[i];
                    r.out_value   = shadow_value[i];
                    r.out_version = shadow_version[i];
                    r.last        = (i == n - 1);
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic send_item(input cmd_t c, input logic [31:0] k, input logic [31:0] v,
                             input logic [31:0] ver, input logic eob);
        in_t item;
        int  gap;
        item.cmd          = c;
        item.key          = k;
        item.value        = v;
        item.in_version   = ver;
        item.end_of_batch = eob;
        if (sender_gaps && burst_left == 0) begin
            gap        = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_table_results(item);
        items_sent++;
    endtask

    // Pick a random version, or one older than, equal to or newer than a base
    function automatic logic [31:0] pick_version(input logic [31:0] k);
        logic [31:0] base;
        int          slot;
        slot = find_entry(k);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: base = shadow_clock;
            default: base = (slot >= 0) ? shadow_version[slot] : $urandom_range(0, 50);
        endcase
        case ($urandom_range(0, 2))
            0: return (base == 0) ? base : base - 1;
            1: return base;
            default: return (base == CLOCK_MAX) ? base : base + 1;
        endcase
    endfunction

    // One message: a batch of same-kind commands, normally closed by end_of_batch
    task automatic send_message(input int fresh_pct);
        int          sel;
        int          len;
        cmd_t        c;
        logic [31:0] k;
        logic        eob;
        sel = $urandom_range(0, 19);
        len = (sel == 19) ? 1 : $urandom_range(1, 5);
        c = (sel <= 6) ? CMD_SET : (sel <= 13) ? CMD_MERGE : (sel <= 18) ? CMD_LOOKUP : CMD_DUMP;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < fresh_pct) k = $urandom;
            else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            eob = (i == len - 1);
            // drop the batch framing now and then
            if ($urandom_range(0, 9) == 0) eob = 1'($urandom_range(0, 1));
            send_item(c, k, $urandom, pick_version(k), eob);
        end
    endtask

    task automatic test_empty_table();
        stall_mode  = 0;
        sender_gaps = 1'b0;
        send_item(CMD_DUMP, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(CMD_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
    endtask

    task automatic test_set_merge_rules();
        stall_mode  = 1;
        sender_gaps = 1'b1;
        send_item(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        send_item(CMD_SET, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1);
        // older and equal versions are ignored
        send_item(CMD_MERGE, 32'h8000_0000, 32'h1234_5678, 32'h1, 1'b0);
        send_item(CMD_MERGE, 32'h8000_0000, 32'h1234_5678, 32'h3, 1'b1);
        send_item(CMD_MERGE, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
        // newer version updates and pulls the clock forward
        send_item(CMD_MERGE, 32'h8000_0000, 32'h0, 32'h0000_0100, 1'b1);
        send_item(CMD_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0200, 1'b0);
        send_item(CMD_MERGE, 32'h0, 32'h0, 32'h0, 1'b1);
        send_item(CMD_SET, 32'h0, 32'h5555_AAAA, 32'h0, 1'b0);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_item(CMD_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_messages();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        while (items_sent < 110) begin
            stall_mode  = (items_sent / 30) % 3;
            sender_gaps = ((items_sent / 20) % 3) != 0;
            send_message(5);
        end
    endtask

    task automatic test_table_full();
        stall_mode  = 2;
        sender_gaps = 1'b1;
        while (shadow_count < MAX_KEYS_DEF) begin
            if ($urandom_range(0, 1)) send_item(CMD_SET, $urandom, $urandom, $urandom, 1'b1);
            else send_item(CMD_MERGE, $urandom, $urandom, $urandom_range(0, 1000), 1'b1);
        end
        send_item(CMD_SET, $urandom, $urandom, $urandom, 1'b0);
        send_item(CMD_MERGE, $urandom, $urandom, $urandom, 1'b1);
        send_item(CMD_DUMP, 32'h0, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = shadow_key[i];
        while (items_sent < 160) begin
            stall_mode = $urandom_range(0, 2);
            send_message(25);
        end
    endtask

    task automatic test_clock_saturation();
        logic [31:0] k0;
        logic [31:0] k1;
        stall_mode  = 1;
        sender_gaps = 1'b1;
        k0 = shadow_key[0];
        k1 = shadow_key[1];
        send_item(CMD_MERGE, k0, $urandom, CLOCK_MAX, 1'b0);
        send_item(CMD_SET, k1, $urandom, 32'h0, 1'b1);
        send_item(CMD_SET, k0, $urandom, 32'h0, 1'b0);
        send_item(CMD_MERGE, k0, $urandom, CLOCK_MAX, 1'b1);
        send_item(CMD_LOOKUP, k1, 32'h0, 32'h0, 1'b0);
        send_item(CMD_DUMP, 32'h0, 32'h0, 32'h0, 1'b1);
    endtask

    always @(posedge aclk) begin : result_check
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: st=%0d key=%h val=%h ver=%h last=%b",
                             m_data.status, m_data.out_key, m_data.out_value,
                             m_data.out_version, m_data.last);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.status !== exp_r.status || m_data.out_key !== exp_r.out_key ||
                    m_data.out_value !== exp_r.out_value ||
                    m_data.out_version !== exp_r.out_version ||
                    m_data.last !== exp_r.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st=%0d key=%h val=%h ver=%h last=%b",
                                 exp_r.status, exp_r.out_key, exp_r.out_value,
                                 exp_r.out_version, exp_r.last,
                                 " | got st=%0d key=%h val=%h ver=%h last=%b",
                                 m_data.status, m_data.out_key, m_data.out_value,
                                 m_data.out_version, m_data.last);
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_set_merge_rules();
        test_random_messages();
        test_table_full();
        test_clock_saturation();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
